[hw/rtl/cpf_pkg.sv]
// Shared constants, widths and the sequencer state type of the cubic path flattener.
package cpf_pkg;

    localparam int COORD_BITS  = 24;
    localparam int MAX_SAMPLES = 63;
    localparam int N_BITS      = 6;
    localparam int W_BITS      = 18;
    localparam int PROD_BITS   = 2 * COORD_BITS;
    localparam int ACC_BITS    = 42;
    localparam int DIV_BITS    = 24;
    localparam int SQ_BITS     = PROD_BITS + 1;
    localparam int SQW_BITS    = SQ_BITS + 1;
    localparam int ROOT_BITS   = 25;
    localparam int LEN_BITS    = 27;
    localparam int CNT_BITS    = 28;
    localparam int STEP_FLOOR  = 26;

    localparam logic [COORD_BITS-1:0] SIGN_FLIP = COORD_BITS'(1) << (COORD_BITS - 1);

    localparam logic [1:0] CMD_MOVE  = 2'd0;
    localparam logic [1:0] CMD_LINE  = 2'd1;
    localparam logic [1:0] CMD_CUBIC = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LINE2,
        S_EMIT,
        S_SQX,
        S_SQY,
        S_SQADD,
        S_SQRT,
        S_CNT,
        S_CNTW,
        S_N2,
        S_N3,
        S_N3C,
        S_WGT,
        S_ACC,
        S_DIVW
    } t_state;

endpackage

[hw/rtl/cubic_path_flattener.sv]
// Top level of the cubic path flattener: sequencer, operand selection and output register.
//
//  Channel   Direction  Handshake               Payload
//  input     in         i_valid / o_stall       i_cmd, i_to_*, i_ctrl1_*, i_ctrl2_*
//  output    out        o_valid / i_stall       o_point_*, o_starts_polyline, o_last,
//                                               o_count_clipped
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_poly_step
//
// A move, or a line with a polyline open, is taken in the idle state and then loads the
// output register from the emit state. A line that first restates the current point passes
// through the emit state twice. A cubic squares and roots each of its three control-net
// legs (the square root unit dominates), divides for the sample count, cubes the count, then
// per sample computes the weights and, per axis, accumulates and divides through the shared
// divider, and finally passes the point to the output register through the emit state.
// Reset is synchronous and active low; it clears the current point, the open flag,
// the output valid and restores the step register to 4.0. A stall on the output
// simply holds the sequencer in its emit state; o_stall is high whenever busy.
module cubic_path_flattener
    import cpf_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_cmd,
    input  logic signed [COORD_BITS-1:0] i_to_x,
    input  logic signed [COORD_BITS-1:0] i_to_y,
    input  logic signed [COORD_BITS-1:0] i_ctrl1_x,
    input  logic signed [COORD_BITS-1:0] i_ctrl1_y,
    input  logic signed [COORD_BITS-1:0] i_ctrl2_x,
    input  logic signed [COORD_BITS-1:0] i_ctrl2_y,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [COORD_BITS-1:0] o_point_x,
    output logic signed [COORD_BITS-1:0] o_point_y,
    output logic                         o_starts_polyline,
    output logic                         o_last,
    output logic                         o_count_clipped,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [COORD_BITS-1:0]        i_cfg_poly_step
);

    t_state r_state, n_state, r_ret;

    // Configuration and architectural state.
    logic [COORD_BITS-1:0] r_step_len;
    logic [COORD_BITS-1:0] r_cur_x, r_cur_y;
    logic                  r_open;

    // The element being worked on.
    logic [COORD_BITS-1:0] r_to_x, r_to_y, r_c1_x, r_c1_y, r_c2_x, r_c2_y;

    // Pending point, waiting for the output register to free up.
    logic [COORD_BITS-1:0] r_px, r_py;
    logic                  r_pst, r_plast, r_clip;

    // Output register.
    logic                  r_o_valid;
    logic [COORD_BITS-1:0] r_ox, r_oy;
    logic                  r_ost, r_olast, r_oclip;

    // Curve working registers.
    logic [1:0]            r_leg;
    logic [PROD_BITS-1:0]  r_sq;
    logic [LEN_BITS-1:0]   r_len;
    logic [N_BITS-1:0]     r_n, r_k;
    logic [W_BITS-1:0]     r_d;
    logic [2:0]            r_sub;
    logic [11:0]           r_j2, r_k2;
    logic [W_BITS-1:0]     r_w0, r_w1, r_w2, r_w3;
    logic                  r_axis;
    logic [ACC_BITS-1:0]   r_acc;
    logic [DIV_BITS-1:0]   r_qx;

    // Shared units.
    logic [COORD_BITS-1:0] mul_a, mul_b;
    logic [PROD_BITS-1:0]  prod;
    logic                  sq_start, sq_done;
    logic [ROOT_BITS-1:0]  root;
    logic                  div_start, div_done;
    logic [ACC_BITS-1:0]   div_num;
    logic [DIV_BITS-1:0]   div_den, quot;

    logic                  in_accept, out_free;
    logic [COORD_BITS-1:0] step_eff;
    logic [COORD_BITS-1:0] leg_ax, leg_ay, leg_bx, leg_by;
    logic [COORD_BITS:0]   diff_x, diff_y;
    logic [COORD_BITS-1:0] mag_x, mag_y;
    logic [N_BITS-1:0]     j_val;
    logic [COORD_BITS-1:0] p0, p1, p2, p3;
    logic [W_BITS-1:0]     prod3;

    assign in_accept   = i_valid && !o_stall;
    assign out_free    = !r_o_valid || !i_stall;
    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Steps below about 0.1 are raised to the floor value.
    assign step_eff = (r_step_len < COORD_BITS'(STEP_FLOOR)) ? COORD_BITS'(STEP_FLOOR)
                                                               : r_step_len;

    // Control-net legs: current point to first control, to second control, to end point.
    always_comb begin
        unique case (r_leg)
            2'd0: begin
                leg_ax = r_cur_x; leg_ay = r_cur_y; leg_bx = r_c1_x; leg_by = r_c1_y;
            end
            2'd1: begin
                leg_ax = r_c1_x; leg_ay = r_c1_y; leg_bx = r_c2_x; leg_by = r_c2_y;
            end
            default: begin
                leg_ax = r_c2_x; leg_ay = r_c2_y; leg_bx = r_to_x; leg_by = r_to_y;
            end
        endcase
    end

    assign diff_x = {leg_bx[COORD_BITS-1], leg_bx} - {leg_ax[COORD_BITS-1], leg_ax};
    assign diff_y = {leg_by[COORD_BITS-1], leg_by} - {leg_ay[COORD_BITS-1], leg_ay};
    assign mag_x  = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
    assign mag_y  = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];

    assign j_val = r_n - r_k;

    // Control points are offset to unsigned so that the weighted sum is never negative;
    // the weights sum to n cubed, so the offset comes back out of the quotient exactly.
    assign p0 = (r_axis ? r_cur_y : r_cur_x) ^ SIGN_FLIP;
    assign p1 = (r_axis ? r_c1_y  : r_c1_x)  ^ SIGN_FLIP;
    assign p2 = (r_axis ? r_c2_y  : r_c2_x)  ^ SIGN_FLIP;
    assign p3 = (r_axis ? r_to_y  : r_to_x)  ^ SIGN_FLIP;

    assign prod3 = prod[W_BITS-1:0] + {prod[W_BITS-2:0], 1'b0};

    // Multiplier operand selection per sequencer step.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SQX: begin
                mul_a = mag_x; mul_b = mag_x;
            end
            S_SQY: begin
                mul_a = mag_y; mul_b = mag_y;
            end
            S_N2: begin
                mul_a = COORD_BITS'(r_n); mul_b = COORD_BITS'(r_n);
            end
            S_N3: begin
                mul_a = prod[COORD_BITS-1:0]; mul_b = COORD_BITS'(r_n);
            end
            S_WGT: begin
                case (r_sub)
                    3'd0: begin mul_a = COORD_BITS'(j_val); mul_b = COORD_BITS'(j_val); end
                    3'd1: begin mul_a = prod[COORD_BITS-1:0]; mul_b = COORD_BITS'(j_val); end
                    3'd2: begin mul_a = COORD_BITS'(r_k); mul_b = COORD_BITS'(r_k); end
                    3'd3: begin mul_a = prod[COORD_BITS-1:0]; mul_b = COORD_BITS'(r_k); end
                    3'd4: begin mul_a = COORD_BITS'(r_j2); mul_b = COORD_BITS'(r_k); end
                    3'd5: begin mul_a = COORD_BITS'(r_k2); mul_b = COORD_BITS'(j_val); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            S_ACC: begin
                case (r_sub)
                    3'd0: begin mul_a = p0; mul_b = COORD_BITS'(r_w0); end
                    3'd1: begin mul_a = p1; mul_b = COORD_BITS'(r_w1); end
                    3'd2: begin mul_a = p2; mul_b = COORD_BITS'(r_w2); end
                    3'd3: begin mul_a = p3; mul_b = COORD_BITS'(r_w3); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            default: begin
                mul_a = '0; mul_b = '0;
            end
        endcase
    end

    assign sq_start  = (r_state == S_SQADD);
    assign div_start = (r_state == S_CNT) || (r_state == S_ACC && r_sub == 3'd4);

    // The count division uses ceil(len / step) as floor((len + step - 1) / step).
    assign div_num = (r_state == S_CNT)
                   ? ACC_BITS'(CNT_BITS'(r_len) + CNT_BITS'(step_eff) - CNT_BITS'(1))
                   : r_acc + prod[ACC_BITS-1:0] + ACC_BITS'(r_d >> 1);
    assign div_den = (r_state == S_CNT) ? step_eff : DIV_BITS'(r_d);

    cpf_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    cpf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (SQ_BITS'(r_sq) + SQ_BITS'(prod)),
        .o_done  (sq_done),
        .o_root  (root)
    );

    cpf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    case (i_cmd)
                        CMD_MOVE:  n_state = S_EMIT;
                        CMD_LINE:  n_state = S_EMIT;
                        CMD_CUBIC: n_state = S_SQX;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_LINE2: n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_state = r_plast ? S_IDLE : r_ret;
                end
            end
            S_SQX:   n_state = S_SQY;
            S_SQY:   n_state = S_SQADD;
            S_SQADD: n_state = S_SQRT;
            S_SQRT: begin
                if (sq_done) begin
                    n_state = (r_leg == 2'd2) ? S_CNT : S_SQX;
                end
            end
            S_CNT: n_state = S_CNTW;
            S_CNTW: begin
                if (div_done) begin
                    n_state = S_N2;
                end
            end
            S_N2:  n_state = S_N3;
            S_N3:  n_state = S_N3C;
            S_N3C: n_state = r_open ? S_WGT : S_EMIT;
            S_WGT: begin
                if (r_sub == 3'd6) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                if (r_sub == 3'd4) begin
                    n_state = S_DIVW;
                end
            end
            S_DIVW: begin
                if (div_done) begin
                    n_state = r_axis ? S_EMIT : S_ACC;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_len <= COORD_BITS'(1024);
            r_cur_x    <= '0;
            r_cur_y    <= '0;
            r_open     <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_step_len <= i_cfg_poly_step;
            end

            if (r_state == S_EMIT && out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_to_x <= i_to_x;    r_to_y <= i_to_y;
                        r_c1_x <= i_ctrl1_x; r_c1_y <= i_ctrl1_y;
                        r_c2_x <= i_ctrl2_x; r_c2_y <= i_ctrl2_y;
                        r_clip <= 1'b0;
                        r_leg  <= 2'd0;
                        r_len  <= '0;
                        if (i_cmd == CMD_MOVE) begin
                            r_px <= i_to_x; r_py <= i_to_y;
                            r_pst <= 1'b1; r_plast <= 1'b1;
                        end else if (i_cmd == CMD_LINE && r_open) begin
                            r_px <= i_to_x; r_py <= i_to_y;
                            r_pst <= 1'b0; r_plast <= 1'b1;
                        end else begin
                            // A line with no polyline open first restates the current point.
                            r_px <= r_cur_x; r_py <= r_cur_y;
                            r_pst <= 1'b1; r_plast <= 1'b0;
                            r_ret <= S_LINE2;
                        end
                    end
                end
                S_LINE2: begin
                    r_px <= r_to_x; r_py <= r_to_y;
                    r_pst <= 1'b0; r_plast <= 1'b1;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ox    <= r_px;
                        r_oy    <= r_py;
                        r_ost   <= r_pst;
                        r_olast <= r_plast;
                        r_oclip <= r_clip;
                        if (r_plast) begin
                            r_cur_x <= r_to_x;
                            r_cur_y <= r_to_y;
                            r_open  <= 1'b1;
                        end
                    end
                end
                S_SQY: r_sq <= prod;
                S_SQRT: begin
                    if (sq_done) begin
                        r_len <= r_len + LEN_BITS'(root);
                        r_leg <= r_leg + 2'd1;
                    end
                end
                S_CNTW: begin
                    if (div_done) begin
                        if (quot > DIV_BITS'(MAX_SAMPLES)) begin
                            r_n    <= N_BITS'(MAX_SAMPLES);
                            r_clip <= 1'b1;
                        end else if (quot == '0) begin
                            r_n <= N_BITS'(1);
                        end else begin
                            r_n <= quot[N_BITS-1:0];
                        end
                        r_k <= N_BITS'(1);
                    end
                end
                S_N3C: begin
                    r_d   <= prod[W_BITS-1:0];
                    r_sub <= '0;
                    r_px  <= r_cur_x; r_py <= r_cur_y;
                    r_pst <= 1'b1; r_plast <= 1'b0;
                    r_ret <= S_WGT;
                end
                S_WGT: begin
                    // Bernstein weights (n-k)^3, 3(n-k)^2 k, 3(n-k) k^2 and k^3.
                    case (r_sub)
                        3'd1: r_j2 <= prod[11:0];
                        3'd2: r_w0 <= prod[W_BITS-1:0];
                        3'd3: r_k2 <= prod[11:0];
                        3'd4: r_w3 <= prod[W_BITS-1:0];
                        3'd5: r_w1 <= prod3;
                        3'd6: r_w2 <= prod3;
                        default: ;
                    endcase
                    r_sub  <= (r_sub == 3'd6) ? 3'd0 : r_sub + 3'd1;
                    r_axis <= 1'b0;
                end
                S_ACC: begin
                    case (r_sub)
                        3'd1:    r_acc <= prod[ACC_BITS-1:0];
                        3'd2:    r_acc <= r_acc + prod[ACC_BITS-1:0];
                        3'd3:    r_acc <= r_acc + prod[ACC_BITS-1:0];
                        default: ;
                    endcase
                    r_sub <= (r_sub == 3'd4) ? 3'd0 : r_sub + 3'd1;
                end
                S_DIVW: begin
                    if (div_done) begin
                        if (!r_axis) begin
                            r_qx   <= quot;
                            r_axis <= 1'b1;
                        end else begin
                            r_px    <= r_qx ^ SIGN_FLIP;
                            r_py    <= quot ^ SIGN_FLIP;
                            r_pst   <= 1'b0;
                            r_plast <= (r_k == r_n);
                            r_ret   <= S_WGT;
                            r_k     <= r_k + N_BITS'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid           = r_o_valid;
    assign o_point_x         = r_ox;
    assign o_point_y         = r_oy;
    assign o_starts_polyline = r_ost;
    assign o_last            = r_olast;
    assign o_count_clipped   = r_oclip;

endmodule

[hw/rtl/cpf_mul.sv]
// Shared registered unsigned multiplier.
module cpf_mul
    import cpf_pkg::*;
(
    input  logic                  i_clk,
    input  logic [COORD_BITS-1:0] i_a,
    input  logic [COORD_BITS-1:0] i_b,
    output logic [PROD_BITS-1:0]  o_prod
);

    logic [PROD_BITS-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_BITS'(i_a) * PROD_BITS'(i_b);
    end

    assign o_prod = r_prod;

endmodule

[hw/rtl/cpf_sqrt.sv]
// Iterative integer square root, two radicand bits per cycle, rounded to nearest.
module cpf_sqrt
    import cpf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [SQ_BITS-1:0]   i_value,
    output logic                 o_done,
    output logic [ROOT_BITS-1:0] o_root
);

    logic                r_busy;
    logic                r_done;
    logic [SQW_BITS-1:0] r_rem;
    logic [SQW_BITS-1:0] r_res;
    logic [SQW_BITS-1:0] r_bit;
    logic [SQW_BITS-1:0] trial;

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= SQW_BITS'(i_value);
                r_res  <= '0;
                r_bit  <= SQW_BITS'(1) << (SQ_BITS - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_rem >= trial) begin
                    r_rem <= r_rem - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit == SQW_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The remainder exceeds the root exactly when the true root lies past the half.
    assign o_done = r_done;
    assign o_root = r_res[ROOT_BITS-1:0] + ROOT_BITS'(r_rem > r_res);

endmodule

[hw/rtl/cpf_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
module cpf_div
    import cpf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [ACC_BITS-1:0] i_dividend,
    input  logic [DIV_BITS-1:0] i_divisor,
    output logic                o_done,
    output logic [DIV_BITS-1:0] o_quot
);

    logic                r_busy;
    logic                r_done;
    logic [4:0]          r_cnt;
    logic [DIV_BITS-1:0] r_rem;
    logic [DIV_BITS-1:0] r_q;
    logic [DIV_BITS-1:0] r_den;
    logic [DIV_BITS:0]   part;
    logic                fits;

    // The caller guarantees the quotient fits, so the top dividend bits start below the divisor.
    assign part = {r_rem, r_q[DIV_BITS-1]};
    assign fits = part >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= DIV_BITS'(i_dividend[ACC_BITS-1:DIV_BITS]);
                r_q    <= i_dividend[DIV_BITS-1:0];
                r_den  <= i_divisor;
                r_cnt  <= 5'(DIV_BITS);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= fits ? DIV_BITS'(part - {1'b0, r_den}) : part[DIV_BITS-1:0];
                r_q   <= {r_q[DIV_BITS-2:0], fits};
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
